// File: hdl/p1305fm_pkg.sv
// Package for the Poly1305 field multiplier: limb widths, split widths and
// the payload types passed between pipeline sections. No dependencies.
package p1305fm_pkg;

    // Limb widths of the radix 2^44 representation
    localparam int LIMB0_W = 44;
    localparam int LIMB_W  = 43;

    // Products per item and columns of the result
    localparam int NPROD = 9;
    localparam int NCOL  = 3;
    localparam int NPP   = 4;

    // Multiplier operand widths: a limb, and a scaled b limb (up to 10 * 2^43)
    localparam int A_W  = 44;
    localparam int B_W  = 48;
    localparam int AH_W = A_W / 2;
    localparam int BH_W = B_W / 2;

    // Partial product, full product and column sum widths
    localparam int PP_W   = AH_W + BH_W;
    localparam int PROD_W = A_W + B_W;
    localparam int COL_W  = PROD_W + 2;

    // Top carry out of limb 2 and the folded limb 0
    localparam int TOP_W = COL_W - LIMB_W;
    localparam int T0_W  = TOP_W + 3;

    // Pipeline depth from operand register to result register
    localparam int NSTAGE = 8;

    typedef struct packed {
        logic [NPROD-1:0][A_W-1:0] a;
        logic [NPROD-1:0][B_W-1:0] b;
    } opnd_t;

    typedef struct packed {
        logic [NPROD-1:0][NPP-1:0][PP_W-1:0] pp;
    } pp_t;

    typedef struct packed {
        logic [NCOL-1:0][COL_W-1:0] c;
    } col_t;

endpackage

// File: hdl/p1305fm_pprod.sv
// Operand staging and partial products of the field multiplier.
// Depends on p1305fm_pkg.
module p1305fm_pprod
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic [p1305fm_pkg::LIMB0_W-1:0]    a_low,
    input  logic [p1305fm_pkg::LIMB_W-1:0]     a_mid,
    input  logic [p1305fm_pkg::LIMB_W-1:0]     a_high,
    input  logic [p1305fm_pkg::LIMB0_W-1:0]    b_low,
    input  logic [p1305fm_pkg::LIMB_W-1:0]     b_mid,
    input  logic [p1305fm_pkg::LIMB_W-1:0]     b_high,
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output p1305fm_pkg::pp_t                   dn_data
);

    localparam int AW  = p1305fm_pkg::A_W;
    localparam int BW  = p1305fm_pkg::B_W;
    localparam int AHW = p1305fm_pkg::AH_W;
    localparam int BHW = p1305fm_pkg::BH_W;
    localparam int PPW = p1305fm_pkg::PP_W;

    p1305fm_pkg::opnd_t opnd_reg;
    p1305fm_pkg::opnd_t opnd_next;
    logic               opnd_valid_reg;
    logic               opnd_en;

    p1305fm_pkg::pp_t   pp_reg;
    p1305fm_pkg::pp_t   pp_next;
    logic               pp_valid_reg;
    logic               pp_en;

    logic [AW-1:0] a0, a1, a2;
    logic [BW-1:0] b0, b1, b2, b1x2, b1x10, b2x5, b2x10;

    // Stage enables: a stage takes new data when empty or draining
    assign pp_en    = !pp_valid_reg || dn_ready;
    assign opnd_en  = !opnd_valid_reg || pp_en;
    assign up_ready = opnd_en;

    // Scale the b limbs for the folded high terms
    always_comb
    begin
        a0    = AW'(a_low);
        a1    = AW'(a_mid);
        a2    = AW'(a_high);
        b0    = BW'(b_low);
        b1    = BW'(b_mid);
        b2    = BW'(b_high);
        b1x2  = b1 << 1;
        b1x10 = (b1 << 3) + (b1 << 1);
        b2x5  = (b2 << 2) + b2;
        b2x10 = b2x5 << 1;

        // Column 0 pairs
        opnd_next.a[0] = a0;  opnd_next.b[0] = b0;
        opnd_next.a[1] = a1;  opnd_next.b[1] = b2x10;
        opnd_next.a[2] = a2;  opnd_next.b[2] = b1x10;
        // Column 1 pairs
        opnd_next.a[3] = a0;  opnd_next.b[3] = b1;
        opnd_next.a[4] = a1;  opnd_next.b[4] = b0;
        opnd_next.a[5] = a2;  opnd_next.b[5] = b2x5;
        // Column 2 pairs
        opnd_next.a[6] = a0;  opnd_next.b[6] = b2;
        opnd_next.a[7] = a1;  opnd_next.b[7] = b1x2;
        opnd_next.a[8] = a2;  opnd_next.b[8] = b0;
    end

    // Split each pair into half-width partial products
    always_comb
    begin
        for (int k = 0; k < p1305fm_pkg::NPROD; k++)
        begin
            pp_next.pp[k][0] = PPW'(opnd_reg.a[k][AHW-1:0])  * PPW'(opnd_reg.b[k][BHW-1:0]);
            pp_next.pp[k][1] = PPW'(opnd_reg.a[k][AW-1:AHW]) * PPW'(opnd_reg.b[k][BHW-1:0]);
            pp_next.pp[k][2] = PPW'(opnd_reg.a[k][AHW-1:0])  * PPW'(opnd_reg.b[k][BW-1:BHW]);
            pp_next.pp[k][3] = PPW'(opnd_reg.a[k][AW-1:AHW]) * PPW'(opnd_reg.b[k][BW-1:BHW]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opnd_valid_reg <= 1'b0;
            pp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (opnd_en)
            begin
                opnd_valid_reg <= up_valid;
            end
            if (pp_en)
            begin
                pp_valid_reg <= opnd_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (opnd_en && up_valid)
        begin
            opnd_reg <= opnd_next;
        end
        if (pp_en && opnd_valid_reg)
        begin
            pp_reg <= pp_next;
        end
    end

    assign dn_valid = pp_valid_reg;
    assign dn_data  = pp_reg;

endmodule

// File: hdl/p1305fm_accum.sv
// Product assembly and column sums of the field multiplier.
// Depends on p1305fm_pkg.
module p1305fm_accum
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  p1305fm_pkg::pp_t     up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output p1305fm_pkg::col_t    dn_data
);

    localparam int AHW   = p1305fm_pkg::AH_W;
    localparam int BHW   = p1305fm_pkg::BH_W;
    localparam int PRODW = p1305fm_pkg::PROD_W;
    localparam int COLW  = p1305fm_pkg::COL_W;
    localparam int NPROD = p1305fm_pkg::NPROD;

    logic [NPROD-1:0][PRODW-1:0] prod_reg;
    logic [NPROD-1:0][PRODW-1:0] prod_next;
    logic                        prod_valid_reg;
    logic                        prod_en;

    p1305fm_pkg::col_t           col_reg;
    p1305fm_pkg::col_t           col_next;
    logic                        col_valid_reg;
    logic                        col_en;

    assign col_en   = !col_valid_reg || dn_ready;
    assign prod_en  = !prod_valid_reg || col_en;
    assign up_ready = prod_en;

    // Shift and add the four partial products of each pair
    always_comb
    begin
        for (int k = 0; k < NPROD; k++)
        begin
            prod_next[k] = PRODW'(up_data.pp[k][0])
                         + (PRODW'(up_data.pp[k][1]) << AHW)
                         + (PRODW'(up_data.pp[k][2]) << BHW)
                         + (PRODW'(up_data.pp[k][3]) << (AHW + BHW));
        end
    end

    // Sum three products into each column
    always_comb
    begin
        for (int j = 0; j < p1305fm_pkg::NCOL; j++)
        begin
            col_next.c[j] = COLW'(prod_reg[3*j]) + COLW'(prod_reg[3*j+1])
                          + COLW'(prod_reg[3*j+2]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            col_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_en)
            begin
                prod_valid_reg <= up_valid;
            end
            if (col_en)
            begin
                col_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (prod_en && up_valid)
        begin
            prod_reg <= prod_next;
        end
        if (col_en && prod_valid_reg)
        begin
            col_reg <= col_next;
        end
    end

    assign dn_valid = col_valid_reg;
    assign dn_data  = col_reg;

endmodule

// File: hdl/p1305fm_carry.sv
// Carry passes and top-carry fold of the field multiplier, ending in the
// result register. Depends on p1305fm_pkg.
module p1305fm_carry
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  p1305fm_pkg::col_t                 up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [p1305fm_pkg::LIMB0_W-1:0]   h_low,
    output logic [p1305fm_pkg::LIMB_W-1:0]    h_mid,
    output logic [p1305fm_pkg::LIMB0_W-1:0]   h_high
);

    localparam int L0W  = p1305fm_pkg::LIMB0_W;
    localparam int LW   = p1305fm_pkg::LIMB_W;
    localparam int COLW = p1305fm_pkg::COL_W;
    localparam int TOPW = p1305fm_pkg::TOP_W;
    localparam int T0W  = p1305fm_pkg::T0_W;

    // Stage E: limb 0 split off, carry into column 1
    logic [L0W-1:0]  e_h0_reg,  e_h0_next;
    logic [COLW-1:0] e_c1_reg,  e_c1_next;
    logic [COLW-1:0] e_c2_reg;
    logic            e_valid_reg, e_en;

    // Stage F: limb 1 split off, carry into column 2
    logic [L0W-1:0]  f_h0_reg;
    logic [LW-1:0]   f_h1_reg;
    logic [LW-1:0]   f_h2_reg;
    logic [TOPW-1:0] f_top_reg;
    logic [COLW-1:0] f_c2_next;
    logic            f_valid_reg, f_en;

    // Stage G: top carry times five folded into limb 0
    logic [T0W-1:0]  g_t0_reg,  g_t0_next;
    logic [LW-1:0]   g_h1_reg;
    logic [LW-1:0]   g_h2_reg;
    logic            g_valid_reg, g_en;

    // Stage H: second carry pass into the result register
    logic [L0W-1:0]  h_h0_reg,  h_h0_next;
    logic [LW-1:0]   h_h1_reg,  h_h1_next;
    logic [L0W-1:0]  h_h2_reg,  h_h2_next;
    logic [L0W-1:0]  s1;
    logic            h_valid_reg, h_en;

    assign h_en     = !h_valid_reg || dn_ready;
    assign g_en     = !g_valid_reg || h_en;
    assign f_en     = !f_valid_reg || g_en;
    assign e_en     = !e_valid_reg || f_en;
    assign up_ready = e_en;

    // Carry arithmetic of each stage
    always_comb
    begin
        e_h0_next = up_data.c[0][L0W-1:0];
        e_c1_next = up_data.c[1] + COLW'(up_data.c[0][COLW-1:L0W]);

        f_c2_next = e_c2_reg + COLW'(e_c1_reg[COLW-1:LW]);

        g_t0_next = (T0W'(f_top_reg) << 2) + T0W'(f_top_reg) + T0W'(f_h0_reg);

        h_h0_next = g_t0_reg[L0W-1:0];
        s1        = L0W'(g_h1_reg) + L0W'(g_t0_reg[T0W-1:L0W]);
        h_h1_next = s1[LW-1:0];
        h_h2_next = L0W'(g_h2_reg) + L0W'(s1[LW]);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_en)
            begin
                e_valid_reg <= up_valid;
            end
            if (f_en)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_en)
            begin
                g_valid_reg <= f_valid_reg;
            end
            if (h_en)
            begin
                h_valid_reg <= g_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (e_en && up_valid)
        begin
            e_h0_reg <= e_h0_next;
            e_c1_reg <= e_c1_next;
            e_c2_reg <= up_data.c[2];
        end
        if (f_en && e_valid_reg)
        begin
            f_h0_reg  <= e_h0_reg;
            f_h1_reg  <= e_c1_reg[LW-1:0];
            f_h2_reg  <= f_c2_next[LW-1:0];
            f_top_reg <= f_c2_next[COLW-1:LW];
        end
        if (g_en && f_valid_reg)
        begin
            g_t0_reg <= g_t0_next;
            g_h1_reg <= f_h1_reg;
            g_h2_reg <= f_h2_reg;
        end
        if (h_en && g_valid_reg)
        begin
            h_h0_reg <= h_h0_next;
            h_h1_reg <= h_h1_next;
            h_h2_reg <= h_h2_next;
        end
    end

    assign dn_valid = h_valid_reg;
    assign h_low    = h_h0_reg;
    assign h_mid    = h_h1_reg;
    assign h_high   = h_h2_reg;

endmodule

// File: hdl/poly1305_field_multiply_unit.sv
// Top level of the Poly1305 field multiplier (mod 2^130-5, radix 2^44).
// Depends on p1305fm_pkg, p1305fm_pprod, p1305fm_accum and p1305fm_carry.
//
// One operand pair is taken per cycle unless the pipeline is stalled. The
// partly reduced product passes through the operand register, 36 partial
// products of 22 by 24 bits, product assembly, column sums, two stages of
// the first carry pass, the top-carry fold, and the second carry pass into
// the result register. Each stage holds its own valid bit, so empty stages
// fill while a result waits at the output, and a stalled result stalls only
// the stages behind it. h_high may reach 2^43; no final subtraction of p is
// done. Reset clears only the valid bits and the in-flight count.
module poly1305_field_multiply_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              operand_valid,
    output logic                              operand_ready,
    input  logic [p1305fm_pkg::LIMB0_W-1:0]   a_low,
    input  logic [p1305fm_pkg::LIMB_W-1:0]    a_mid,
    input  logic [p1305fm_pkg::LIMB_W-1:0]    a_high,
    input  logic [p1305fm_pkg::LIMB0_W-1:0]   b_low,
    input  logic [p1305fm_pkg::LIMB_W-1:0]    b_mid,
    input  logic [p1305fm_pkg::LIMB_W-1:0]    b_high,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [p1305fm_pkg::LIMB0_W-1:0]   h_low,
    output logic [p1305fm_pkg::LIMB_W-1:0]    h_mid,
    output logic [p1305fm_pkg::LIMB0_W-1:0]   h_high
);

    localparam int CNT_W = $clog2(p1305fm_pkg::NSTAGE + 1);

    p1305fm_pkg::pp_t  pp_data;
    logic              pp_valid, pp_ready;
    p1305fm_pkg::col_t col_data;
    logic              col_valid, col_ready;

    logic [CNT_W-1:0]  inflight_reg;
    logic [CNT_W-1:0]  inflight_next;
    logic              in_fire, out_fire;

    // Partial products
    p1305fm_pprod u_pprod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (operand_valid),
        .up_ready (operand_ready),
        .a_low    (a_low),
        .a_mid    (a_mid),
        .a_high   (a_high),
        .b_low    (b_low),
        .b_mid    (b_mid),
        .b_high   (b_high),
        .dn_valid (pp_valid),
        .dn_ready (pp_ready),
        .dn_data  (pp_data)
    );

    // Products and column sums
    p1305fm_accum u_accum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pp_valid),
        .up_ready (pp_ready),
        .up_data  (pp_data),
        .dn_valid (col_valid),
        .dn_ready (col_ready),
        .dn_data  (col_data)
    );

    // Carry passes and result register
    p1305fm_carry u_carry
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (col_valid),
        .up_ready (col_ready),
        .up_data  (col_data),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .h_low    (h_low),
        .h_mid    (h_mid),
        .h_high   (h_high)
    );

    // Track transactions inside the pipeline
    assign in_fire  = operand_valid && operand_ready;
    assign out_fire = result_valid && result_ready;

    always_comb
    begin
        inflight_next = inflight_reg + CNT_W'(in_fire) - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // Never more transactions in flight than stages
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(p1305fm_pkg::NSTAGE))
        else $error("more transactions in flight than pipeline stages");

    // A result only shows while a transaction is in flight
    a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (inflight_reg != '0))
        else $error("result shown with no transaction in flight");

    // An empty pipeline always takes an operand
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> operand_ready)
        else $error("empty pipeline refuses operands");

    // The top limb reaches 2^43 only with its low bits clear
    a_top_limb: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && h_high[p1305fm_pkg::LIMB_W])
            |-> (h_high[p1305fm_pkg::LIMB_W-1:0] == '0))
        else $error("top limb exceeds 2^43");

endmodule
